// ===== hdl/advection_stencil_1d_assert.svh =====
// assertion macros for the advection stencil block
`ifndef ADVECTION_STENCIL_1D_ASSERT_SVH
`define ADVECTION_STENCIL_1D_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define ADVST_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("advection stencil assertion failed");
`define ADVST_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("advection stencil assertion failed");
`else
`define ADVST_ASSERT(lbl, prop)
`define ADVST_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== hdl/advst_pkg.sv =====
package advst_pkg;

    localparam int SAMPLE_W    = 24;
    localparam int COURANT_W   = 18;
    localparam int CEFF_W      = COURANT_W + 1;
    localparam int HALF_W      = 17;
    localparam int SQ_W        = 2 * COURANT_W;
    localparam int DIFF1_W     = SAMPLE_W + 1;
    localparam int DIFF2_W     = SAMPLE_W + 2;
    localparam int PROD_W      = DIFF2_W + CEFF_W;
    localparam int SUM_W       = SAMPLE_W + 6;
    localparam int ADDR_W      = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] MODE_CENTRAL = 2'd0;
    localparam logic [1:0] MODE_UPWIND  = 2'd1;
    localparam logic [1:0] MODE_LAXW    = 2'd2;

    localparam logic [1:0] REG_SCHEME    = 2'd0;
    localparam logic [1:0] REG_COURANT   = 2'd1;
    localparam logic [1:0] REG_DIRECTION = 2'd2;

    localparam logic [1:0] OP_ZERO    = 2'd0;
    localparam logic [1:0] OP_CENTRAL = 2'd1;
    localparam logic [1:0] OP_UPWIND  = 2'd2;
    localparam logic [1:0] OP_LAXW    = 2'd3;

    localparam logic [1:0] ROW_EMPTY = 2'd0;
    localparam logic [1:0] ROW_ONE   = 2'd1;
    localparam logic [1:0] ROW_MANY  = 2'd2;

    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic [HALF_W-1:0]          HALF_MAX = {HALF_W{1'b1}};

    typedef struct packed {
        logic [1:0]                  kind;
        logic                        last;
        logic signed [SAMPLE_W-1:0]  x;
        logic signed [DIFF1_W-1:0]   diff1;
        logic signed [DIFF2_W-1:0]   diff2;
    } op_t;

    typedef struct packed {
        logic signed [CEFF_W-1:0] courant;
        logic [HALF_W-1:0]        half_sq;
    } coef_t;

    typedef struct packed {
        logic [1:0] row_pos;
        logic       pend_valid;
    } front_status_t;

endpackage

// ===== hdl/advst_front.sv =====
module advst_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [1:0]                      scheme_mode,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [advst_pkg::SAMPLE_W-1:0]  in_sample,
    input  logic                            in_last,
    output logic                            push,
    output advst_pkg::op_t                  push_op,
    input  logic                            queue_ready,
    output advst_pkg::front_status_t        status
);
    import advst_pkg::*;

    logic [1:0]                 row_pos_reg, row_pos_next;
    logic signed [SAMPLE_W-1:0] prev_reg, prev_next;
    logic signed [SAMPLE_W-1:0] prev2_reg, prev2_next;
    logic                       pend_valid_reg, pend_valid_next;
    op_t                        pend_reg, pend_next;

    logic                       accept;
    logic signed [SAMPLE_W-1:0] cur;
    logic                       a_valid, b_valid;
    op_t                        op_a, op_b;
    logic [1:0]                 mode_kind;

    assign cur      = $signed(in_sample);
    assign in_ready = !pend_valid_reg && queue_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        case (scheme_mode)
            MODE_UPWIND: mode_kind = OP_UPWIND;
            MODE_LAXW:   mode_kind = OP_LAXW;
            default:     mode_kind = OP_CENTRAL;
        endcase
    end

    // previous-position request
    always_comb
    begin
        a_valid     = row_pos_reg != ROW_EMPTY;
        op_a.last   = 1'b0;
        op_a.x      = prev_reg;
        op_a.diff2  = DIFF2_W'(cur) - (DIFF2_W'(prev_reg) <<< 1) + DIFF2_W'(prev2_reg);
        if (mode_kind == OP_UPWIND)
        begin
            op_a.diff1 = DIFF1_W'(prev_reg) - DIFF1_W'(prev2_reg);
        end
        else
        begin
            op_a.diff1 = DIFF1_W'(cur) - DIFF1_W'(prev2_reg);
        end
        op_a.kind = (row_pos_reg == ROW_ONE) ? OP_ZERO : mode_kind;
    end

    // final-position request
    always_comb
    begin
        b_valid    = in_last;
        op_b.last  = 1'b1;
        op_b.x     = cur;
        op_b.diff1 = DIFF1_W'(cur) - DIFF1_W'(prev_reg);
        op_b.diff2 = '0;
        if (mode_kind == OP_UPWIND && row_pos_reg != ROW_EMPTY)
        begin
            op_b.kind = OP_UPWIND;
        end
        else
        begin
            op_b.kind = OP_ZERO;
        end
    end

    always_comb
    begin
        row_pos_next    = row_pos_reg;
        prev_next       = prev_reg;
        prev2_next      = prev2_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        push            = 1'b0;
        push_op         = op_a;
        if (pend_valid_reg)
        begin
            push_op = pend_reg;
            if (queue_ready)
            begin
                push            = 1'b1;
                pend_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (a_valid)
            begin
                push            = 1'b1;
                push_op         = op_a;
                pend_valid_next = b_valid;
                pend_next       = op_b;
            end
            else if (b_valid)
            begin
                push    = 1'b1;
                push_op = op_b;
            end
            if (in_last)
            begin
                row_pos_next = ROW_EMPTY;
                prev_next    = '0;
                prev2_next   = '0;
            end
            else
            begin
                prev2_next = prev_reg;
                prev_next  = cur;
                if (row_pos_reg != ROW_MANY)
                begin
                    row_pos_next = row_pos_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos_reg    <= ROW_EMPTY;
            prev_reg       <= '0;
            prev2_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            row_pos_reg    <= row_pos_next;
            prev_reg       <= prev_next;
            prev2_reg      <= prev2_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

    assign status.row_pos    = row_pos_reg;
    assign status.pend_valid = pend_valid_reg;

endmodule

// ===== hdl/advst_queue.sv =====
module advst_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  advst_pkg::op_t  push_op,
    output logic            ready,
    input  logic            pop,
    output logic            valid,
    output advst_pkg::op_t  head
);
    import advst_pkg::*;

    op_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign ready   = count_reg != (QPTR_W+1)'(QUEUE_DEPTH);
    assign valid   = count_reg != '0;
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && ready;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// ===== hdl/advst_back.sv =====
module advst_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  advst_pkg::coef_t                coef,
    input  logic                            op_valid,
    output logic                            op_pop,
    input  advst_pkg::op_t                  op,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [advst_pkg::SAMPLE_W-1:0]  out_value,
    output logic                            out_last
);
    import advst_pkg::*;

    // multiply stage
    logic                       v1_reg, v1_next;
    logic [1:0]                 kind1_reg;
    logic                       last1_reg;
    logic signed [SAMPLE_W-1:0] x1_reg;
    logic signed [PROD_W-1:0]   prod_c_reg, prod_h_reg;
    // rounding stage
    logic                       v2_reg, v2_next;
    logic [1:0]                 kind2_reg;
    logic                       last2_reg;
    logic signed [SAMPLE_W-1:0] x2_reg;
    logic signed [SUM_W-1:0]    term_c_reg, term_h_reg;
    // output register
    logic                       ov_reg, ov_next;
    logic signed [SAMPLE_W-1:0] value_reg, value_next;
    logic                       last_reg;

    logic                       rdy1, rdy2, rdy3;
    logic signed [HALF_W:0]     half_s;
    logic signed [PROD_W-1:0]   prod_c, prod_h;
    logic signed [PROD_W-1:0]   rnd_c, rnd_h;
    logic signed [SUM_W-1:0]    sum;

    assign rdy3   = !ov_reg || out_ready;
    assign rdy2   = !v2_reg || rdy3;
    assign rdy1   = !v1_reg || rdy2;
    assign op_pop = op_valid && rdy1;

    assign half_s = {1'b0, coef.half_sq};
    assign prod_c = PROD_W'(op.diff1) * PROD_W'(coef.courant);
    assign prod_h = PROD_W'(op.diff2) * PROD_W'(half_s);

    always_comb
    begin
        if (kind1_reg == OP_UPWIND)
        begin
            rnd_c = (prod_c_reg + PROD_W'(32768)) >>> 16;
        end
        else
        begin
            rnd_c = (prod_c_reg + PROD_W'(65536)) >>> 17;
        end
        if (kind1_reg == OP_LAXW)
        begin
            rnd_h = (prod_h_reg + PROD_W'(32768)) >>> 16;
        end
        else
        begin
            rnd_h = '0;
        end
    end

    always_comb
    begin
        sum = SUM_W'(x2_reg) - term_c_reg + term_h_reg;
        if (kind2_reg == OP_ZERO)
        begin
            value_next = '0;
        end
        else if (sum > SUM_W'(SAT_MAX))
        begin
            value_next = SAT_MAX;
        end
        else if (sum < SUM_W'(SAT_MIN))
        begin
            value_next = SAT_MIN;
        end
        else
        begin
            value_next = sum[SAMPLE_W-1:0];
        end
    end

    always_comb
    begin
        v1_next = rdy1 ? op_valid : v1_reg;
        v2_next = rdy2 ? v1_reg : v2_reg;
        ov_next = rdy3 ? v2_reg : ov_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            kind1_reg  <= op.kind;
            last1_reg  <= op.last;
            x1_reg     <= op.x;
            prod_c_reg <= prod_c;
            prod_h_reg <= prod_h;
        end
        if (rdy2)
        begin
            kind2_reg  <= kind1_reg;
            last2_reg  <= last1_reg;
            x2_reg     <= x1_reg;
            term_c_reg <= rnd_c[SUM_W-1:0];
            term_h_reg <= rnd_h[SUM_W-1:0];
        end
        if (rdy3)
        begin
            value_reg <= value_next;
            last_reg  <= last2_reg;
        end
    end

    assign out_valid = ov_reg;
    assign out_value = value_reg;
    assign out_last  = last_reg;

endmodule

// ===== hdl/advection_stencil_1d.sv =====
// One time step of 1-D linear advection over a streamed row (central, upwind or
// Lax-Wendroff, chosen by scheme_mode). Samples enter one per clock while s_tready
// is high; each sample but the first of its row releases the update of the position
// before it, and the sample that carries tlast also releases the final position,
// so a row of n samples gives n results. A tlast sample that follows at least one
// other sample of its row yields two results and holds s_tready low while the second
// is queued. Results pass through the queue, multiply stage, rounding stage and
// output register, the second result of a tlast sample following the first; a
// four-entry queue lets the input run on while the output is stalled. A sample may
// follow a configuration write at once, as the derived coefficients are registered
// before it reaches the multiply stage.
`include "advection_stencil_1d_assert.svh"

module advection_stencil_1d (
    input  logic                           clk,
    input  logic                           rst_n,
    // apb configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [advst_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    // input samples
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [23:0]                    s_tdata,   // sample_value
    input  logic                           s_tlast,   // row_end
    // updated values
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [23:0]                    m_tdata,   // updated_value
    output logic                           m_tlast    // row_end_out
);
    import advst_pkg::*;

    logic [1:0]                  scheme_reg;
    logic [COURANT_W-1:0]        courant_reg;
    logic                        fwd_reg;
    coef_t                       coef_reg, coef_next;

    logic                        cfg_write;
    logic [1:0]                  cfg_index;
    logic signed [CEFF_W-1:0]    c_ext;
    logic signed [SQ_W-1:0]      c_sq;
    logic [SQ_W-1:0]             h_full;

    logic                        q_push, q_ready, q_valid, q_pop;
    op_t                         q_in, q_head;
    front_status_t               fstat;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scheme_reg  <= MODE_CENTRAL;
            courant_reg <= '0;
            fwd_reg     <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SCHEME:    scheme_reg  <= pwdata[1:0];
                REG_COURANT:   courant_reg <= pwdata[COURANT_W-1:0];
                REG_DIRECTION: fwd_reg     <= pwdata[0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_SCHEME:    prdata = 32'(scheme_reg);
            REG_COURANT:   prdata = 32'(courant_reg);
            REG_DIRECTION: prdata = 32'(fwd_reg);
            default:       prdata = '0;
        endcase
    end

    // effective courant number and half its square
    always_comb
    begin
        c_ext  = CEFF_W'($signed(courant_reg));
        c_sq   = SQ_W'($signed(courant_reg)) * SQ_W'($signed(courant_reg));
        h_full = (c_sq + SQ_W'(65536)) >> 17;
        coef_next.courant = fwd_reg ? c_ext : -c_ext;
        coef_next.half_sq = (h_full > SQ_W'(HALF_MAX)) ? HALF_MAX : h_full[HALF_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    advst_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .scheme_mode (scheme_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_sample   (s_tdata),
        .in_last     (s_tlast),
        .push        (q_push),
        .push_op     (q_in),
        .queue_ready (q_ready),
        .status      (fstat)
    );

    advst_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (q_in),
        .ready   (q_ready),
        .pop     (q_pop),
        .valid   (q_valid),
        .head    (q_head)
    );

    advst_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .coef      (coef_reg),
        .op_valid  (q_valid),
        .op_pop    (q_pop),
        .op        (q_head),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_value (m_tdata),
        .out_last  (m_tlast)
    );

    `ADVST_ASSERT(a_row_restart, (s_tvalid && s_tready && s_tlast) |=> (fstat.row_pos == ROW_EMPTY))
    `ADVST_ASSERT(a_row_advance, (s_tvalid && s_tready && !s_tlast) |=> (fstat.row_pos != ROW_EMPTY))
    `ADVST_ASSERT(a_pend_stall, fstat.pend_valid |-> !s_tready)
    `ADVST_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> (!m_tvalid && !fstat.pend_valid))

endmodule
